@@ hdl/rcpd_pkg.sv @@
// ----------------------------------------------------------------------------
// Reciprocal digit generator package
// Shared types, widths and codes for the reciprocal digit generator.
// ----------------------------------------------------------------------------
package rcpd_pkg;

    localparam int DIV_BITS   = 31;
    localparam int DIGIT_BITS = 32;
    localparam int CNT_BITS   = 16;
    localparam int ITER_BITS  = $clog2(DIGIT_BITS);

    localparam logic [CNT_BITS-1:0] MAX_DIGITS_RESET = CNT_BITS'(1024 * 16);

    localparam logic [1:0] STAT_DIGIT  = 2'd0;
    localparam logic [1:0] STAT_LIMIT  = 2'd1;
    localparam logic [1:0] STAT_PERIOD = 2'd2;
    localparam logic [1:0] STAT_IDLE   = 2'd3;

    typedef struct packed {
        logic                func;
        logic [DIV_BITS-1:0] divisor;
    } req_t;

    typedef struct packed {
        logic [DIGIT_BITS-1:0] digit;
        logic [CNT_BITS-1:0]   position;
        logic [1:0]            status;
        logic [DIV_BITS-1:0]   remainder;
    } rsp_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE
    } state_t;

    typedef enum logic [1:0] {
        K_START,
        K_NEXT,
        K_NONE
    } kind_t;

endpackage

@@ hdl/rcpd_div.sv @@
// ----------------------------------------------------------------------------
// Reciprocal digit divider
// Radix-2 restoring divider: divides {hi, 32 zero bits} by the divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcpd_div
    import rcpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIV_BITS-1:0]   hi,
    input  logic [DIV_BITS-1:0]   divisor,
    output div_stat_t             stat,
    output logic [DIGIT_BITS-1:0] quotient,
    output logic [DIV_BITS-1:0]   remainder
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [ITER_BITS-1:0]  iter_reg, iter_next;
    logic [DIV_BITS-1:0]   rem_reg, rem_next;
    logic [DIV_BITS-1:0]   dvs_reg, dvs_next;
    logic [DIGIT_BITS-1:0] quo_reg, quo_next;

    logic [DIV_BITS:0]     trial;
    logic [DIV_BITS:0]     diff;
    logic                  ge;

    assign trial = {rem_reg, 1'b0};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            rem_next  = hi;
            dvs_next  = divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
            quo_next  = {quo_reg[DIGIT_BITS-2:0], ge};
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_BITS'(DIGIT_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ hdl/reciprocal_digit_generator.sv @@
// ----------------------------------------------------------------------------
// Reciprocal digit generator
// Emits the base 2^32 digits of 1/divisor, detects the period and stops at a
// programmable digit limit.
// ----------------------------------------------------------------------------
// A start transfer (func 0) loads the divisor and returns digit 0; each next
// transfer (func 1) returns the following digit. A digit is made by one
// radix-2 divider that produces one quotient bit per cycle; the quotient is
// then handed over to the write state, which loads it into the output
// register once that register is free. Transfers that need no division (no
// run active, divisor below two) go from acceptance straight to the write
// state. Only one item is in work at a time; req_ready is low from
// acceptance until its result is loaded into the output register, which may
// still be waiting for rsp_ready while the next item is taken.
module reciprocal_digit_generator
    import rcpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  req_t                req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rsp_t                rsp,
    input  logic                cfg_wr_en,
    input  logic [CNT_BITS-1:0] cfg_wr_data
);

    state_t                state_reg, state_next;
    kind_t                 kind_reg, kind_next;
    logic [CNT_BITS-1:0]   max_digits_reg;
    logic [DIV_BITS-1:0]   divisor_held_reg, divisor_held_next;
    logic [DIV_BITS-1:0]   running_rem_reg, running_rem_next;
    logic [DIGIT_BITS-1:0] first_digit_reg, first_digit_next;
    logic [DIV_BITS-1:0]   first_rem_reg, first_rem_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  active_reg, active_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;

    logic                  accept;
    logic                  load;
    kind_t                 req_kind;
    logic                  div_start;
    logic [DIV_BITS-1:0]   div_hi;
    logic [DIV_BITS-1:0]   div_divisor;
    div_stat_t             div_stat;
    logic [DIGIT_BITS-1:0] quo;
    logic [DIV_BITS-1:0]   rem;
    logic [CNT_BITS-1:0]   lim;
    logic [CNT_BITS-1:0]   count_inc;

    rcpd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .hi        (div_hi),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (quo),
        .remainder (rem)
    );

    assign accept    = req_valid && req_ready;
    assign lim       = (max_digits_reg == '0) ? CNT_BITS'(1) : max_digits_reg;
    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        if (!req.func)
        begin
            req_kind = (req.divisor < DIV_BITS'(2)) ? K_NONE : K_START;
        end
        else
        begin
            req_kind = active_reg ? K_NEXT : K_NONE;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_kind == K_NONE) ? ST_WRITE : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req_ready = 1'b0;
        load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:  req_ready = 1'b1;
            ST_DIV:   req_ready = 1'b0;
            ST_WRITE: load      = !rsp_valid_reg || rsp_ready;
            default:  req_ready = 1'b0;
        endcase
    end

    assign div_start   = accept && (req_kind != K_NONE);
    assign div_hi      = req.func ? running_rem_reg : DIV_BITS'(1);
    assign div_divisor = req.func ? divisor_held_reg : req.divisor;

    // result and run state
    always_comb
    begin
        kind_next         = kind_reg;
        divisor_held_next = divisor_held_reg;
        running_rem_next  = running_rem_reg;
        first_digit_next  = first_digit_reg;
        first_rem_next    = first_rem_reg;
        count_next        = count_reg;
        active_next       = active_reg;
        rsp_next          = rsp_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp_ready;

        if (accept)
        begin
            kind_next = req_kind;
            if (req_kind == K_START)
            begin
                divisor_held_next = req.divisor;
            end
            if (!req.func)
            begin
                active_next = 1'b0;
            end
        end

        if (load)
        begin
            rsp_valid_next = 1'b1;
            case (kind_reg)
                K_START:
                begin
                    first_digit_next = quo;
                    first_rem_next   = rem;
                    running_rem_next = rem;
                    count_next       = CNT_BITS'(1);
                    rsp_next.digit     = quo;
                    rsp_next.position  = '0;
                    rsp_next.remainder = rem;
                    if (lim == CNT_BITS'(1))
                    begin
                        active_next     = 1'b0;
                        rsp_next.status = STAT_LIMIT;
                    end
                    else
                    begin
                        active_next     = 1'b1;
                        rsp_next.status = STAT_DIGIT;
                    end
                end
                K_NEXT:
                begin
                    running_rem_next   = rem;
                    rsp_next.position  = count_reg;
                    rsp_next.remainder = rem;
                    if (quo == first_digit_reg && rem == first_rem_reg)
                    begin
                        active_next     = 1'b0;
                        rsp_next.digit  = '0;
                        rsp_next.status = STAT_PERIOD;
                    end
                    else
                    begin
                        count_next     = count_inc;
                        rsp_next.digit = quo;
                        if (count_inc >= lim || count_inc == '0)
                        begin
                            active_next     = 1'b0;
                            rsp_next.status = STAT_LIMIT;
                        end
                        else
                        begin
                            rsp_next.status = STAT_DIGIT;
                        end
                    end
                end
                default:
                begin
                    rsp_next.digit     = '0;
                    rsp_next.position  = '0;
                    rsp_next.status    = STAT_IDLE;
                    rsp_next.remainder = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            kind_reg         <= K_NONE;
            max_digits_reg   <= MAX_DIGITS_RESET;
            divisor_held_reg <= '0;
            running_rem_reg  <= '0;
            first_digit_reg  <= '0;
            first_rem_reg    <= '0;
            count_reg        <= '0;
            active_reg       <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            kind_reg         <= kind_next;
            if (cfg_wr_en)
            begin
                max_digits_reg <= cfg_wr_data;
            end
            divisor_held_reg <= divisor_held_next;
            running_rem_reg  <= running_rem_next;
            first_digit_reg  <= first_digit_next;
            first_rem_reg    <= first_rem_next;
            count_reg        <= count_next;
            active_reg       <= active_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ hdl/rcpd_checker.sv @@
// ----------------------------------------------------------------------------
// Reciprocal digit generator checker
// Port-level properties of the reciprocal digit generator, bound to the top.
// ----------------------------------------------------------------------------
module rcpd_checker
    import rcpd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input req_t                req,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input rsp_t                rsp,
    input logic                cfg_wr_en,
    input logic [CNT_BITS-1:0] cfg_wr_data
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed or dropped");

    // one item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous item still in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STAT_PERIOD |-> rsp.digit == '0 && rsp.position != '0)
    else $error("period result with digit set or zero length");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STAT_IDLE
            |-> rsp.digit == '0 && rsp.position == '0 && rsp.remainder == '0)
    else $error("no-run result carries data");

endmodule

bind reciprocal_digit_generator rcpd_checker u_rcpd_checker (.*);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Reciprocal digit generator testbench
// Drives start and next transfers into the digit generator and checks every
// result against a cycle-free long-division predictor. The digit limit is
// reprogrammed between phases. Runs end by period, by limit, or are abandoned.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top
    import rcpd_pkg::*;
;

    localparam int LIMIT_CYCLES = 800000;
    localparam int RANDOM_WORK  = 1650;
    localparam int QUIET_FROM   = 1450;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    req_t                req;
    logic                rsp_valid;
    logic                rsp_ready;
    rsp_t                rsp;
    logic                cfg_wr_en;
    logic [CNT_BITS-1:0] cfg_wr_data;

    bit idle_on;
    int work_done;
    int cycle_count;

    class recip_scoreboard;
        bit [CNT_BITS-1:0]   limit_reg;
        bit [DIV_BITS-1:0]   dvsr;
        bit [DIV_BITS-1:0]   carry_rem;
        bit [DIGIT_BITS-1:0] lead_digit;
        bit [DIV_BITS-1:0]   lead_rem;
        bit [CNT_BITS-1:0]   digits_made;
        bit                  in_run;
        rsp_t                digits_due[$];
        int                  errors;
        int                  seen[4];

        function new();
            limit_reg   = MAX_DIGITS_RESET;
            dvsr        = '0;
            carry_rem   = '0;
            lead_digit  = '0;
            lead_rem    = '0;
            digits_made = '0;
            in_run      = 1'b0;
            errors      = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        function void set_limit(bit [CNT_BITS-1:0] v);
            limit_reg = v;
        endfunction

        function bit [CNT_BITS-1:0] eff_limit();
            return (limit_reg == 0) ? CNT_BITS'(1) : limit_reg;
        endfunction

        function void take_request(req_t r);
            rsp_t      want;
            bit [63:0] num;
            bit [63:0] q;
            bit [63:0] rm;
            want = '0;
            if (r.func == 1'b0)
            begin
                if (r.divisor < 2)
                begin
                    in_run      = 1'b0;
                    want.status = STAT_IDLE;
                end
                else
                begin
                    num         = 64'd1 << 32;
                    q           = num / {33'd0, r.divisor};
                    rm          = num % {33'd0, r.divisor};
                    dvsr        = r.divisor;
                    lead_digit  = q[DIGIT_BITS-1:0];
                    lead_rem    = rm[DIV_BITS-1:0];
                    carry_rem   = rm[DIV_BITS-1:0];
                    digits_made = CNT_BITS'(1);
                    want.digit     = q[DIGIT_BITS-1:0];
                    want.remainder = rm[DIV_BITS-1:0];
                    in_run      = !(digits_made >= eff_limit());
                    want.status = in_run ? STAT_DIGIT : STAT_LIMIT;
                end
            end
            else if (!in_run || dvsr < 2)
            begin
                want.status = STAT_IDLE;
            end
            else
            begin
                num = {1'b0, carry_rem, 32'd0};
                q   = num / {33'd0, dvsr};
                rm  = num % {33'd0, dvsr};
                want.position  = digits_made;
                want.remainder = rm[DIV_BITS-1:0];
                carry_rem      = rm[DIV_BITS-1:0];
                if (q[DIGIT_BITS-1:0] == lead_digit && rm[DIV_BITS-1:0] == lead_rem)
                begin
                    in_run      = 1'b0;
                    want.status = STAT_PERIOD;
                end
                else
                begin
                    digits_made = digits_made + 1'b1;
                    want.digit  = q[DIGIT_BITS-1:0];
                    if (digits_made >= eff_limit() || digits_made == 0)
                    begin
                        in_run      = 1'b0;
                        want.status = STAT_LIMIT;
                    end
                    else
                    begin
                        want.status = STAT_DIGIT;
                    end
                end
            end
            digits_due.push_back(want);
        endfunction

        function void match_response(rsp_t got);
            rsp_t want;
            if (digits_due.size() == 0)
            begin
                $error("result with nothing pending: %h", got);
                errors++;
                return;
            end
            want = digits_due.pop_front();
            if (got.digit !== want.digit)
            begin
                $error("digit: expected %h, got %h", want.digit, got.digit);
                errors++;
            end
            if (got.position !== want.position)
            begin
                $error("position: expected %0d, got %0d", want.position, got.position);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.remainder !== want.remainder)
            begin
                $error("remainder: expected %h, got %h", want.remainder, got.remainder);
                errors++;
            end
            seen[want.status]++;
        endfunction
    endclass

    recip_scoreboard sb;

    reciprocal_digit_generator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.match_response(rsp);
    end

    // stall the result side in bursts
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
                rsp_ready <= 1'b1;
            end
        end
    end

    function automatic logic [DIV_BITS-1:0] pick_divisor();
        case ($urandom_range(0, 9))
            0, 1, 2: return DIV_BITS'($urandom_range(2, 300));
            3, 4:
            begin
                case ($urandom_range(0, 15))
                    0:  return DIV_BITS'(3);
                    1:  return DIV_BITS'(5);
                    2:  return DIV_BITS'(7);
                    3:  return DIV_BITS'(13);
                    4:  return DIV_BITS'(17);
                    5:  return DIV_BITS'(97);
                    6:  return DIV_BITS'(241);
                    7:  return DIV_BITS'(257);
                    8:  return DIV_BITS'(641);
                    9:  return DIV_BITS'(673);
                    10: return DIV_BITS'(21845);
                    11: return DIV_BITS'(65535);
                    12: return DIV_BITS'(65537);
                    13: return DIV_BITS'(6700417);
                    14: return DIV_BITS'(42009217);
                    default: return DIV_BITS'(1722007169);
                endcase
            end
            5: return DIV_BITS'(1) << $urandom_range(1, 30);
            6:
            begin
                case ($urandom_range(0, 3))
                    0: return DIV_BITS'(2);
                    1: return DIV_BITS'(3);
                    2: return 31'h7FFF_FFFE;
                    default: return 31'h7FFF_FFFF;
                endcase
            end
            default: return DIV_BITS'($urandom_range(32'h7FFF_FFFF, 2));
        endcase
    endfunction

    // hold valid until the transfer, with an optional gap in front
    task automatic send(input logic f, input logic [DIV_BITS-1:0] d);
        req_t item;
        item.func    = f;
        item.divisor = d;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        sb.take_request(item);
        work_done++;
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.digits_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [CNT_BITS-1:0] v);
        drain();
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        sb.set_limit(v);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_sequence();
        int cap;
        cap = $urandom_range(1, 70);
        send(1'b0, pick_divisor());
        while (sb.in_run && cap > 0)
        begin
            send(1'b1, DIV_BITS'($urandom()));
            cap--;
        end
        if ($urandom_range(0, 5) == 0)
            send(1'b1, DIV_BITS'($urandom()));
    endtask

    initial
    begin
        logic [CNT_BITS-1:0] lim;
        sb          = new();
        idle_on     = 1'b0;
        work_done   = 0;
        cycle_count = 0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        rsp_ready   = 1'b1;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idle_on = 1'b1;
        send(1'b1, '1);
        send(1'b0, '0);
        send(1'b0, DIV_BITS'(1));
        send(1'b0, DIV_BITS'(2));
        send(1'b1, '0);
        send(1'b0, DIV_BITS'(3));
        send(1'b1, '0);
        send(1'b0, DIV_BITS'(7));
        repeat (3) send(1'b1, 31'h5555_5555);
        send(1'b0, 31'h7FFF_FFFF);
        send(1'b1, '1);
        send(1'b0, DIV_BITS'(6700417));
        repeat (2) send(1'b1, '0);
        send(1'b0, DIV_BITS'(2147483629));
        repeat (3) send(1'b1, 31'h2AAA_AAAA);
        // lower the limit under the digit count of a live run
        write_limit(CNT_BITS'(3));
        send(1'b1, '0);
        send(1'b1, '0);
        write_limit('0);
        send(1'b0, DIV_BITS'(10));
        write_limit(CNT_BITS'(1));
        send(1'b0, 31'h2AAA_AAAB);
        write_limit(16'hFFFF);
        send(1'b0, DIV_BITS'(5));
        send(1'b1, '0);

        work_done = 0;
        while (work_done < RANDOM_WORK)
        begin
            case ($urandom_range(0, 9))
                0:       lim = '0;
                1:       lim = CNT_BITS'(1);
                2:       lim = 16'hFFFF;
                3, 4:    lim = CNT_BITS'($urandom());
                default: lim = CNT_BITS'($urandom_range(2, 64));
            endcase
            write_limit(lim);
            idle_on = (work_done < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(4, 12))
            begin
                if ($urandom_range(0, 4) != 0)
                    run_sequence();
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       send(1'b0, DIV_BITS'($urandom_range(0, 1)));
                        1:       send(1'b0, DIV_BITS'($urandom()));
                        default: send(1'b1, DIV_BITS'($urandom()));
                    endcase
                end
            end
        end

        idle_on = 1'b0;
        drain();
        repeat (40) @(posedge clk);
        if (sb.digits_due.size() != 0)
        begin
            $error("%0d results never arrived", sb.digits_due.size());
            sb.errors++;
        end
        $display("Checked %0d digits, %0d limit stops, %0d periods, %0d idle answers",
                 sb.seen[STAT_DIGIT], sb.seen[STAT_LIMIT], sb.seen[STAT_PERIOD],
                 sb.seen[STAT_IDLE]);
        $display("Limits ranged over 0, 1, small, random and full scale; %0d cycles run",
                 cycle_count);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/rcpd_pkg.sv
hdl/rcpd_div.sv
hdl/reciprocal_digit_generator.sv
hdl/rcpd_checker.sv
tb/tb_top.sv
